/* src/ptts_pkg.sv */
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types, codes and helpers of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int TASK_SLOTS    = 8;
   localparam int COUNT_BITS    = 16;
   localparam int SLOT_BITS     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int SCAN_BITS     = $clog2(TASK_SLOTS + 1);
   localparam int DIVIDE_BITS   = 7;
   localparam int WATCHDOG_BITS = 16;
   localparam int ID_BITS       = 3;
   localparam int CSR_BITS      = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 32;

   localparam logic [DIVIDE_BITS-1:0]   FAST_DIVIDE_RESET    = 7'd5;
   localparam logic [DIVIDE_BITS-1:0]   SLOW_DIVIDE_RESET    = 7'd10;
   localparam logic [WATCHDOG_BITS-1:0] WATCHDOG_LIMIT_RESET = 16'd200;

   localparam logic [CSR_BITS-1:0] CSR_FAST_DIVIDE    = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_SLOW_DIVIDE    = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_WATCHDOG_LIMIT = 2'd2;

   localparam logic [1:0] SS_NONE      = 2'd0;
   localparam logic [1:0] SS_SUSPENDED = 2'd1;
   localparam logic [1:0] SS_ACTIVE    = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_CREATE    = 3'd1,
      OP_SUSPEND   = 3'd2,
      OP_RESUME    = 3'd3,
      OP_QUERY     = 3'd4,
      OP_DISPATCH  = 3'd5,
      OP_SET_TIMER = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL       = 2'd1,
      ST_NO_TASK    = 2'd2,
      ST_NONE_READY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_MODIFY,
      S_FETCH,
      S_LATCH
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] period;
      logic [COUNT_BITS-1:0] countdown;
      logic [COUNT_BITS-1:0] timer;
   } slot_row_type;

   typedef struct packed {
      logic                 we;
      logic [SLOT_BITS-1:0] waddr;
      slot_row_type         wdata;
      logic [SLOT_BITS-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [2:0]            operation;
      logic [ID_BITS-1:0]    task_id;
      logic [COUNT_BITS-1:0] period_ticks;
      logic [COUNT_BITS-1:0] timer_ticks;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  task_index;
      logic [1:0]  pause_state;
      logic [15:0] running_timer;
      logic        fast_flag;
      logic        slow_flag;
      logic        watchdog_error;
   } res_type;

   typedef struct packed {
      logic tick;
      logic flag_clear;
      logic wd_clear;
   } tb_ctrl_type;

   typedef struct packed {
      logic fast_pending;
      logic slow_pending;
      logic wd_error;
   } tb_stat_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] idx;
   } pick_type;

   function automatic pick_type first_set(logic [TASK_SLOTS-1:0] vec);
      pick_type p;
      p = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            p.found = 1'b1;
            p.idx   = SLOT_BITS'(i);
         end
      end
      return p;
   endfunction

endpackage

/* src/ptts_slot_mem.sv */
// ----------------------------------------------------------------------------
// ptts_slot_mem
// Slot memory: period, countdown and timer per slot, one write and one
// registered read per cycle. Never-written rows read as zero.
// ----------------------------------------------------------------------------
module ptts_slot_mem (
   input  logic                  clock,
   input  logic                  reset,
   input  ptts_pkg::mem_req_type mem_req,
   output ptts_pkg::slot_row_type rd_row
);

   ptts_pkg::slot_row_type             mem [ptts_pkg::TASK_SLOTS];
   ptts_pkg::slot_row_type             rd_ff;
   logic                               rd_valid_ff;
   logic                               rd_valid_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    valid_ff;
   logic [ptts_pkg::TASK_SLOTS-1:0]    valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (mem_req.we) begin
         valid_in[mem_req.waddr] = 1'b1;
      end
      rd_valid_in = valid_ff[mem_req.raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_ff <= mem[mem_req.raddr];
   end

   assign rd_row = rd_valid_ff ? rd_ff : '0;

endmodule

/* src/ptts_timebase.sv */
// ----------------------------------------------------------------------------
// ptts_timebase
// Configuration registers, fast and slow prescalers, pending flags and the
// saturating watchdog count.
// ----------------------------------------------------------------------------
module ptts_timebase (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ptts_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [ptts_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   input  ptts_pkg::tb_ctrl_type              tb_ctrl,
   output ptts_pkg::tb_stat_type              tb_stat
);

   logic [ptts_pkg::DIVIDE_BITS-1:0]   fast_div_ff, fast_div_in;
   logic [ptts_pkg::DIVIDE_BITS-1:0]   slow_div_ff, slow_div_in;
   logic [ptts_pkg::WATCHDOG_BITS-1:0] wd_limit_ff, wd_limit_in;
   logic [ptts_pkg::DIVIDE_BITS-1:0]   fast_count_ff, fast_count_in;
   logic [ptts_pkg::DIVIDE_BITS-1:0]   slow_count_ff, slow_count_in;
   logic                               fast_pend_ff, fast_pend_in;
   logic                               slow_pend_ff, slow_pend_in;
   logic [ptts_pkg::WATCHDOG_BITS-1:0] wd_count_ff, wd_count_in;
   logic [ptts_pkg::DIVIDE_BITS-1:0]   fast_sum;
   logic [ptts_pkg::DIVIDE_BITS-1:0]   slow_sum;
   logic                               fast_fire;
   logic                               slow_fire;

   assign fast_sum  = fast_count_ff + 1'b1;
   assign slow_sum  = slow_count_ff + 1'b1;
   assign fast_fire = (fast_sum >= fast_div_ff);
   assign slow_fire = (slow_sum >= slow_div_ff);

   always_comb begin
      fast_div_in = fast_div_ff;
      slow_div_in = slow_div_ff;
      wd_limit_in = wd_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            ptts_pkg::CSR_FAST_DIVIDE:    fast_div_in = csr_wdata[ptts_pkg::DIVIDE_BITS-1:0];
            ptts_pkg::CSR_SLOW_DIVIDE:    slow_div_in = csr_wdata[ptts_pkg::DIVIDE_BITS-1:0];
            ptts_pkg::CSR_WATCHDOG_LIMIT: wd_limit_in = csr_wdata[ptts_pkg::WATCHDOG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      fast_count_in = fast_count_ff;
      slow_count_in = slow_count_ff;
      fast_pend_in  = fast_pend_ff;
      slow_pend_in  = slow_pend_ff;
      wd_count_in   = wd_count_ff;
      if (tb_ctrl.tick) begin
         fast_count_in = fast_fire ? '0 : fast_sum;
         if (fast_fire) begin
            fast_pend_in  = 1'b1;
            slow_count_in = slow_fire ? '0 : slow_sum;
            if (slow_fire) begin
               slow_pend_in = 1'b1;
            end
            if (wd_count_ff != '1) begin
               wd_count_in = wd_count_ff + 1'b1;
            end
         end
      end
      if (tb_ctrl.flag_clear) begin
         fast_pend_in = 1'b0;
         slow_pend_in = 1'b0;
      end
      if (tb_ctrl.wd_clear) begin
         wd_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_div_ff   <= ptts_pkg::FAST_DIVIDE_RESET;
         slow_div_ff   <= ptts_pkg::SLOW_DIVIDE_RESET;
         wd_limit_ff   <= ptts_pkg::WATCHDOG_LIMIT_RESET;
         fast_count_ff <= '0;
         slow_count_ff <= '0;
         fast_pend_ff  <= 1'b0;
         slow_pend_ff  <= 1'b0;
         wd_count_ff   <= '0;
      end else begin
         fast_div_ff   <= fast_div_in;
         slow_div_ff   <= slow_div_in;
         wd_limit_ff   <= wd_limit_in;
         fast_count_ff <= fast_count_in;
         slow_count_ff <= slow_count_in;
         fast_pend_ff  <= fast_pend_in;
         slow_pend_ff  <= slow_pend_in;
         wd_count_ff   <= wd_count_in;
      end
   end

   assign tb_stat.fast_pending = fast_pend_ff;
   assign tb_stat.slow_pending = slow_pend_ff;
   assign tb_stat.wd_error     = fast_fire && (wd_count_ff > wd_limit_ff);

endmodule

/* src/ptts_sched.sv */
// ----------------------------------------------------------------------------
// ptts_sched
// Command sequencer: slot flags, read-modify-write of the slot memory,
// tick scan over all slots and result assembly.
// ----------------------------------------------------------------------------
module ptts_sched (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  ptts_pkg::req_type      req,
   input  logic                   rsp_free,
   output logic                   res_load,
   output ptts_pkg::res_type      res,
   output ptts_pkg::mem_req_type  mem_req,
   input  ptts_pkg::slot_row_type rd_row,
   output ptts_pkg::tb_ctrl_type  tb_ctrl,
   input  ptts_pkg::tb_stat_type  tb_stat
);

   ptts_pkg::state_type                state_ff, state_in;
   logic [ptts_pkg::SCAN_BITS-1:0]     scan_ff, scan_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    exists_ff, exists_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    ready_ff, ready_in;
   logic [ptts_pkg::TASK_SLOTS-1:0]    susp_ff, susp_in;
   logic [ptts_pkg::SLOT_BITS-1:0]     running_ff, running_in;
   logic [ptts_pkg::COUNT_BITS-1:0]    tval_ff, tval_in;
   ptts_pkg::res_type                  res_ff, res_in;
   logic                               accept;
   logic                               scan_done;
   logic                               id_ok;
   logic [ptts_pkg::SLOT_BITS-1:0]     id_idx;
   logic [ptts_pkg::SLOT_BITS-1:0]     wb_idx;
   logic [ptts_pkg::COUNT_BITS-1:0]    cd_dec;
   ptts_pkg::pick_type                 pick_free;
   ptts_pkg::pick_type                 pick_ready;

   assign req_tready = (state_ff == ptts_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign scan_done  = (scan_ff == ptts_pkg::SCAN_BITS'(ptts_pkg::TASK_SLOTS));
   assign id_ok      = (32'(req.task_id) < ptts_pkg::TASK_SLOTS) && exists_ff[id_idx];
   assign id_idx     = req.task_id[ptts_pkg::SLOT_BITS-1:0];
   assign wb_idx     = ptts_pkg::SLOT_BITS'(scan_ff - 1'b1);
   assign cd_dec     = rd_row.countdown - 1'b1;
   assign pick_free  = ptts_pkg::first_set(~exists_ff);
   assign pick_ready = ptts_pkg::first_set(ready_ff & exists_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptts_pkg::S_IDLE: begin
            if (accept) begin
               unique case (ptts_pkg::op_type'(req.operation))
                  ptts_pkg::OP_TICK:      state_in = ptts_pkg::S_SCAN;
                  ptts_pkg::OP_SET_TIMER: state_in = ptts_pkg::S_MODIFY;
                  default:                state_in = ptts_pkg::S_FETCH;
               endcase
            end
         end
         ptts_pkg::S_SCAN:   if (scan_done) state_in = ptts_pkg::S_FETCH;
         ptts_pkg::S_MODIFY: state_in = ptts_pkg::S_FETCH;
         ptts_pkg::S_FETCH:  state_in = ptts_pkg::S_LATCH;
         ptts_pkg::S_LATCH:  if (rsp_free) state_in = ptts_pkg::S_IDLE;
         default:            state_in = ptts_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      scan_in       = scan_ff;
      exists_in     = exists_ff;
      ready_in      = ready_ff;
      susp_in       = susp_ff;
      running_in    = running_ff;
      tval_in       = tval_ff;
      res_in        = res_ff;
      res_load      = 1'b0;
      tb_ctrl       = '0;
      mem_req       = '0;
      mem_req.raddr = running_ff;

      unique case (state_ff)
         ptts_pkg::S_IDLE: begin
            if (accept) begin
               res_in  = '0;
               tval_in = req.timer_ticks;
               scan_in = '0;
               unique case (ptts_pkg::op_type'(req.operation))
                  ptts_pkg::OP_TICK: begin
                     tb_ctrl.tick          = 1'b1;
                     res_in.watchdog_error = tb_stat.wd_error;
                  end
                  ptts_pkg::OP_CREATE: begin
                     if (pick_free.found) begin
                        mem_req.we                = 1'b1;
                        mem_req.waddr             = pick_free.idx;
                        mem_req.wdata.period      = req.period_ticks;
                        mem_req.wdata.countdown   = req.period_ticks;
                        mem_req.wdata.timer       = '0;
                        exists_in[pick_free.idx]  = 1'b1;
                        ready_in[pick_free.idx]   = 1'b1;
                        susp_in[pick_free.idx]    = 1'b0;
                        res_in.task_index         = 3'(pick_free.idx);
                     end else begin
                        res_in.status = ptts_pkg::ST_FULL;
                     end
                  end
                  ptts_pkg::OP_SUSPEND, ptts_pkg::OP_RESUME, ptts_pkg::OP_QUERY: begin
                     res_in.task_index = req.task_id;
                     if (id_ok) begin
                        if (ptts_pkg::op_type'(req.operation) == ptts_pkg::OP_SUSPEND) begin
                           susp_in[id_idx] = 1'b1;
                        end else if (ptts_pkg::op_type'(req.operation) ==
                                     ptts_pkg::OP_RESUME) begin
                           susp_in[id_idx] = 1'b0;
                        end
                        res_in.pause_state = susp_in[id_idx] ? ptts_pkg::SS_SUSPENDED
                                                             : ptts_pkg::SS_ACTIVE;
                     end else begin
                        res_in.status      = ptts_pkg::ST_NO_TASK;
                        res_in.pause_state = ptts_pkg::SS_NONE;
                     end
                  end
                  ptts_pkg::OP_DISPATCH: begin
                     tb_ctrl.flag_clear = 1'b1;
                     res_in.fast_flag   = tb_stat.fast_pending;
                     res_in.slow_flag   = tb_stat.slow_pending;
                     if (pick_ready.found) begin
                        ready_in[pick_ready.idx] = 1'b0;
                        running_in               = pick_ready.idx;
                        res_in.task_index        = 3'(pick_ready.idx);
                     end else begin
                        res_in.status    = ptts_pkg::ST_NONE_READY;
                        tb_ctrl.wd_clear = 1'b1;
                     end
                  end
                  ptts_pkg::OP_SET_TIMER: begin
                     res_in.task_index = 3'(running_ff);
                  end
                  default: ;
               endcase
            end
         end
         ptts_pkg::S_SCAN: begin
            mem_req.raddr = ptts_pkg::SLOT_BITS'(scan_ff);
            scan_in       = scan_ff + 1'b1;
            if (scan_ff != '0) begin
               mem_req.we              = 1'b1;
               mem_req.waddr           = wb_idx;
               mem_req.wdata           = rd_row;
               mem_req.wdata.timer     = (rd_row.timer != '0) ? rd_row.timer - 1'b1 : '0;
               if (susp_ff[wb_idx]) begin
                  ready_in[wb_idx] = 1'b0;
               end else if (rd_row.period != '0) begin
                  if (cd_dec == '0) begin
                     mem_req.wdata.countdown = rd_row.period;
                     ready_in[wb_idx]        = 1'b1;
                  end else begin
                     mem_req.wdata.countdown = cd_dec;
                  end
               end
            end
         end
         ptts_pkg::S_MODIFY: begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = running_ff;
            mem_req.wdata       = rd_row;
            mem_req.wdata.timer = tval_ff;
         end
         ptts_pkg::S_FETCH: ;
         ptts_pkg::S_LATCH: begin
            if (rsp_free) begin
               res_load = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ptts_pkg::S_IDLE;
         scan_ff    <= '0;
         exists_ff  <= '0;
         ready_ff   <= '0;
         susp_ff    <= '0;
         running_ff <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         exists_ff  <= exists_in;
         ready_ff   <= ready_in;
         susp_ff    <= susp_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      tval_ff <= tval_in;
      res_ff  <= res_in;
   end

   always_comb begin
      res               = res_ff;
      res.running_timer = rd_row.timer;
   end

endmodule

/* src/periodic_task_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Cooperative time-triggered task scheduler over a small slot memory.
//
//   channel  dir  fields (low bit first)
//   req_     in   tuser: operation; tdata: task_id, period_ticks, timer_ticks
//   rsp_     out  tdata: status, task_index, pause_state, running_timer,
//                        fast_flag, slow_flag, watchdog_error
//   csr_     in   we, index (0 fast_divide, 1 slow_divide, 2 watchdog_limit)
//
// One item at a time. A tick makes a read-modify-write pass over
// the slot memory, one slot per cycle, plus the running task's timer fetch.
// Set-timer adds a modify step ahead of the fetch and latch that end every operation.
// Synchronous reset; the slot rows need no clearing pass (valid bits).
// The result sits in an output register; a new item is taken while it waits.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [2:0]                         req_tuser,  // operation
   input  logic [ptts_pkg::REQ_DATA_BITS-1:0] req_tdata,  // task_id, period_ticks, timer_ticks
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ptts_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // status, task_index, pause_state,
                                                          // running_timer, fast_flag,
                                                          // slow_flag, watchdog_error
   input  logic                               csr_we,
   input  logic [ptts_pkg::CSR_BITS-1:0]      csr_index,
   input  logic [ptts_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   ptts_pkg::req_type                  req;
   ptts_pkg::res_type                  res;
   ptts_pkg::mem_req_type              mem_req;
   ptts_pkg::slot_row_type             rd_row;
   ptts_pkg::tb_ctrl_type              tb_ctrl;
   ptts_pkg::tb_stat_type              tb_stat;
   logic                               res_load;
   logic                               rsp_free;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ptts_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   assign req.operation    = req_tuser;
   assign req.task_id      = req_tdata[2:0];
   assign req.period_ticks = req_tdata[18:3];
   assign req.timer_ticks  = req_tdata[34:19];

   ptts_timebase u_timebase (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tb_ctrl   (tb_ctrl),
      .tb_stat   (tb_stat)
   );

   ptts_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_row  (rd_row)
   );

   ptts_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req        (req),
      .rsp_free   (rsp_free),
      .res_load   (res_load),
      .res        (res),
      .mem_req    (mem_req),
      .rd_row     (rd_row),
      .tb_ctrl    (tb_ctrl),
      .tb_stat    (tb_stat)
   );

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, res.watchdog_error, res.slow_flag, res.fast_flag,
                         res.running_timer, res.pause_state, res.task_index,
                         res.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/ptts_checker.sv */
// ----------------------------------------------------------------------------
// ptts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ptts_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ptts_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in work");

   a_state_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[6:5] != 2'd0) |-> (rsp_tdata[1:0] == 2'd0 &&
                                                 rsp_tdata[6:5] != 2'd3))
      else $error("suspend state with bad status or code");

   a_tick_dispatch: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> (!rsp_tdata[23] && !rsp_tdata[24]))
      else $error("watchdog error together with dispatch flags");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/sv/periodic_task_tick_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_tb
// Drives scheduler commands and ticks into the block under random gaps and
// receiver stalls, predicts every reply from a private copy of the task table,
// prescalers and watchdog, and checks each reply field by field in order.
// Runs a directed opening, then random traffic under several divider and
// watchdog settings, the extremes among them.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0]                    OP_SPARE         = 3'd7;
   localparam logic [ptts_pkg::CSR_BITS-1:0] CSR_SPARE        = 2'd3;
   localparam int                            CYCLE_LIMIT      = 600_000;
   localparam int                            DRAIN_CYCLES     = 24;
   localparam int                            HOLD_CYCLES      = 400;
   localparam int                            RANDOM_PER_PHASE = 230;
   localparam int                            PHASES           = 5;

   class task_table_scoreboard;
      bit [6:0]          fast_div;
      bit [6:0]          slow_div;
      bit [15:0]         wd_limit;
      bit                present[ptts_pkg::TASK_SLOTS];
      bit                runnable[ptts_pkg::TASK_SLOTS];
      bit                parked[ptts_pkg::TASK_SLOTS];
      bit [15:0]         reload[ptts_pkg::TASK_SLOTS];
      bit [15:0]         down[ptts_pkg::TASK_SLOTS];
      bit [15:0]         oneshot[ptts_pkg::TASK_SLOTS];
      bit [2:0]          current;
      bit [6:0]          fast_ticks;
      bit [6:0]          slow_ticks;
      bit                fast_seen;
      bit                slow_seen;
      bit [15:0]         wd_periods;
      ptts_pkg::res_type expected_replies[$];
      int                mismatches;

      function new();
         fast_div   = ptts_pkg::FAST_DIVIDE_RESET;
         slow_div   = ptts_pkg::SLOW_DIVIDE_RESET;
         wd_limit   = ptts_pkg::WATCHDOG_LIMIT_RESET;
         current    = '0;
         fast_ticks = '0;
         slow_ticks = '0;
         fast_seen  = 1'b0;
         slow_seen  = 1'b0;
         wd_periods = '0;
         mismatches = 0;
         for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
            present[i]  = 1'b0;
            runnable[i] = 1'b0;
            parked[i]   = 1'b0;
            reload[i]   = '0;
            down[i]     = '0;
            oneshot[i]  = '0;
         end
      endfunction

      function void configure(logic [ptts_pkg::CSR_BITS-1:0] idx, logic [15:0] value);
         case (idx)
            ptts_pkg::CSR_FAST_DIVIDE:    fast_div = value[6:0];
            ptts_pkg::CSR_SLOW_DIVIDE:    slow_div = value[6:0];
            ptts_pkg::CSR_WATCHDOG_LIMIT: wd_limit = value;
            default: ;
         endcase
      endfunction

      function int waiting();
         return expected_replies.size();
      endfunction

      function bit step_tick();
         bit hit;
         hit = 1'b0;
         fast_ticks = fast_ticks + 7'd1;
         if (fast_ticks >= fast_div) begin
            if (wd_periods > wd_limit) hit = 1'b1;
            if (wd_periods != 16'hFFFF) wd_periods = wd_periods + 16'd1;
            fast_ticks = '0;
            fast_seen  = 1'b1;
            slow_ticks = slow_ticks + 7'd1;
            if (slow_ticks >= slow_div) begin
               slow_ticks = '0;
               slow_seen  = 1'b1;
            end
         end
         for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
            if (oneshot[i] != 16'd0) oneshot[i] = oneshot[i] - 16'd1;
            if (!parked[i]) begin
               if (reload[i] != 16'd0) begin
                  down[i] = down[i] - 16'd1;
                  if (down[i] == 16'd0) begin
                     down[i]     = reload[i];
                     runnable[i] = 1'b1;
                  end
               end
            end else begin
               runnable[i] = 1'b0;
            end
         end
         return hit;
      endfunction

      function void note_request(logic [2:0] op, logic [2:0] id, logic [15:0] per,
                                 logic [15:0] tmr);
         ptts_pkg::res_type r;
         r = '0;
         r.status = ptts_pkg::ST_OK;
         case (op)
            ptts_pkg::OP_TICK: r.watchdog_error = step_tick();
            ptts_pkg::OP_CREATE: begin
               r.status = ptts_pkg::ST_FULL;
               for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
                  if (!present[i]) begin
                     present[i]   = 1'b1;
                     runnable[i]  = 1'b1;
                     parked[i]    = 1'b0;
                     reload[i]    = per;
                     down[i]      = per;
                     oneshot[i]   = '0;
                     r.status     = ptts_pkg::ST_OK;
                     r.task_index = 3'(i);
                     break;
                  end
               end
            end
            ptts_pkg::OP_SUSPEND, ptts_pkg::OP_RESUME, ptts_pkg::OP_QUERY: begin
               r.task_index = id;
               if (present[id]) begin
                  if (op == ptts_pkg::OP_SUSPEND) parked[id] = 1'b1;
                  else if (op == ptts_pkg::OP_RESUME) parked[id] = 1'b0;
                  r.pause_state = parked[id] ? ptts_pkg::SS_SUSPENDED : ptts_pkg::SS_ACTIVE;
               end else begin
                  r.status = ptts_pkg::ST_NO_TASK;
               end
            end
            ptts_pkg::OP_DISPATCH: begin
               r.fast_flag = fast_seen;
               r.slow_flag = slow_seen;
               fast_seen   = 1'b0;
               slow_seen   = 1'b0;
               r.status    = ptts_pkg::ST_NONE_READY;
               for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++) begin
                  if (runnable[i] && present[i]) begin
                     runnable[i]  = 1'b0;
                     current      = 3'(i);
                     r.status     = ptts_pkg::ST_OK;
                     r.task_index = 3'(i);
                     break;
                  end
               end
               if (r.status == ptts_pkg::ST_NONE_READY) wd_periods = '0;
            end
            ptts_pkg::OP_SET_TIMER: begin
               oneshot[current] = tmr;
               r.task_index     = current;
            end
            default: ;
         endcase
         r.running_timer = oneshot[current];
         expected_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_reply(logic [ptts_pkg::RSP_DATA_BITS-1:0] data);
         ptts_pkg::res_type e;
         if (expected_replies.size() == 0) begin
            $error("reply %h with no item outstanding", data);
            mismatches++;
            return;
         end
         e = expected_replies.pop_front();
         compare_field("status", 16'(e.status), 16'(data[1:0]));
         compare_field("task_index", 16'(e.task_index), 16'(data[4:2]));
         compare_field("pause_state", 16'(e.pause_state), 16'(data[6:5]));
         compare_field("running_timer", e.running_timer, data[22:7]);
         compare_field("fast_flag", 16'(e.fast_flag), 16'(data[23]));
         compare_field("slow_flag", 16'(e.slow_flag), 16'(data[24]));
         compare_field("watchdog_error", 16'(e.watchdog_error), 16'(data[25]));
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [2:0]                         req_tuser;   // operation
   logic [ptts_pkg::REQ_DATA_BITS-1:0] req_tdata;   // task_id, period_ticks, timer_ticks
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   logic [ptts_pkg::RSP_DATA_BITS-1:0] rsp_tdata;   // status, task_index, pause_state,
                                                    // running_timer, fast_flag, slow_flag,
                                                    // watchdog_error
   logic                               csr_we;
   logic [ptts_pkg::CSR_BITS-1:0]      csr_index;
   logic [ptts_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   task_table_scoreboard table_check;
   int                   sent = 0;
   int                   cycles = 0;

   periodic_task_tick_scheduler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         table_check.note_request(req_tuser, req_tdata[2:0], req_tdata[18:3], req_tdata[34:19]);
      if (!reset && rsp_tvalid && rsp_tready)
         table_check.check_reply(rsp_tdata);
   end

   // result side: random stalls, quiet stretches, and a long hold now and then
   initial begin
      int taken;
      int stall;
      taken = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 280 == 140) stall = HOLD_CYCLES;
         else if (((taken / 50) % 4) == 1) stall = 0;
         else stall = $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   task automatic send_item(logic [2:0] op, logic [2:0] id, logic [15:0] per, logic [15:0] tmr);
      int gap;
      gap = (((sent / 40) % 4) == 2) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {5'b0, tmr, per, id};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   function automatic logic [15:0] draw_count();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick < 7) return 16'($urandom_range(1, 12));
      return 16'($urandom);
   endfunction

   task automatic send_random();
      int         pick;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 40) op = ptts_pkg::OP_TICK;
      else if (pick < 44) op = ptts_pkg::OP_CREATE;
      else if (pick < 51) op = ptts_pkg::OP_SUSPEND;
      else if (pick < 58) op = ptts_pkg::OP_RESUME;
      else if (pick < 65) op = ptts_pkg::OP_QUERY;
      else if (pick < 88) op = ptts_pkg::OP_DISPATCH;
      else if (pick < 98) op = ptts_pkg::OP_SET_TIMER;
      else op = OP_SPARE;
      send_item(op, 3'($urandom_range(0, 7)), draw_count(), draw_count());
   endtask

   // drop valid and wait until every reply is back and the block is quiet
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (table_check.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(logic [6:0] fdiv, logic [6:0] sdiv, logic [15:0] wlim);
      drain();
      csr_we    <= 1'b1;
      csr_index <= ptts_pkg::CSR_FAST_DIVIDE;
      csr_wdata <= {9'b0, fdiv};
      @(posedge clock);
      csr_index <= ptts_pkg::CSR_SLOW_DIVIDE;
      csr_wdata <= {9'b0, sdiv};
      @(posedge clock);
      csr_index <= ptts_pkg::CSR_WATCHDOG_LIMIT;
      csr_wdata <= wlim;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= 16'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      table_check.configure(ptts_pkg::CSR_FAST_DIVIDE, {9'b0, fdiv});
      table_check.configure(ptts_pkg::CSR_SLOW_DIVIDE, {9'b0, sdiv});
      table_check.configure(ptts_pkg::CSR_WATCHDOG_LIMIT, wlim);
   endtask

   task automatic run_directed();
      send_item(ptts_pkg::OP_QUERY, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_SUSPEND, 3'd7, 16'hFFFF, 16'hFFFF);
      send_item(ptts_pkg::OP_RESUME, 3'd5, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_SET_TIMER, 3'd0, 16'd0, 16'hFFFF);
      send_item(ptts_pkg::OP_CREATE, 3'd7, 16'd0, 16'hFFFF);
      send_item(ptts_pkg::OP_CREATE, 3'd0, 16'hFFFF, 16'd0);
      send_item(ptts_pkg::OP_CREATE, 3'd0, 16'd1, 16'd0);
      send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_SUSPEND, 3'd1, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_QUERY, 3'd1, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_SET_TIMER, 3'd0, 16'd0, 16'd2);
      send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_RESUME, 3'd1, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0);
      send_item(ptts_pkg::OP_DISPATCH, 3'd0, 16'd0, 16'd0);
      send_item(OP_SPARE, 3'd7, 16'hFFFF, 16'hFFFF);
      for (int k = 0; k < 6; k++)
         send_item(ptts_pkg::OP_CREATE, 3'd0, (k == 4) ? 16'hFFFF : 16'(k + 2), 16'd0);
   endtask

   initial begin
      table_check = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_config(7'd0, 7'd0, 16'd0);
            1: write_config(7'd127, 7'd127, 16'hFFFF);
            2: write_config(7'd1, 7'd1, 16'd3);
            3: write_config(7'd2, 7'd3, 16'd12);
            default: write_config(7'($urandom_range(1, 8)), 7'($urandom_range(1, 6)),
                                  16'($urandom_range(0, 40)));
         endcase
         repeat (RANDOM_PER_PHASE) send_random();
      end
      drain();
      if (table_check.mismatches == 0 && table_check.waiting() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* files.f */
src/ptts_pkg.sv
src/ptts_slot_mem.sv
src/ptts_timebase.sv
src/ptts_sched.sv
src/periodic_task_tick_scheduler.sv
src/ptts_checker.sv
tb/sv/periodic_task_tick_scheduler_tb.sv
